// ===== design/hsvc_pkg.sv =====
// Shared constants, stage record and helper for the HSV/RGB pixel converter.
package hsvc_pkg;

    // Component width; FULL stands for 1.0
    localparam int CB = 16;
    localparam logic [CB-1:0] FULL = {CB{1'b1}};

    // Working widths: hue scaled by six and the biased hue numerator (up to ten
    // deltas plus a channel), dividend of the hue quotient, product width
    localparam int DW = CB + 4;
    localparam int HW = 2 * CB + 3;
    localparam int PW = 2 * CB;

    // Pipeline depth: one entry stage, one scaling stage, one stage per quotient bit
    localparam int NS = CB + 2;

    // Direction codes
    localparam logic CMD_HSV2RGB = 1'b0;
    localparam logic CMD_RGB2HSV = 1'b1;

    // Sextant codes
    localparam logic [2:0] SEXT_0 = 3'd0;
    localparam logic [2:0] SEXT_1 = 3'd1;
    localparam logic [2:0] SEXT_2 = 3'd2;
    localparam logic [2:0] SEXT_3 = 3'd3;
    localparam logic [2:0] SEXT_4 = 3'd4;
    localparam logic [2:0] SEXT_WRAP = 3'd6;

    // One pipeline stage's payload
    typedef struct packed {
        logic          cmd;
        logic          last;
        logic          flat;   // zero saturation, or all channels equal
        logic [2:0]    sext;
        logic [CB-1:0] v;
        logic [CB-1:0] s;
        logic [CB-1:0] fr;
        logic [PW-1:0] x0;
        logic [PW-1:0] x1;
        logic [PW-1:0] x2;
        logic [CB-1:0] r0;
        logic [CB-1:0] r1;
        logic [CB-1:0] r2;
        logic [HW-1:0] hrem;
        logic [DW-1:0] hdiv;
        logic [CB-1:0] hq;
        logic [PW-1:0] srem;
        logic [CB-1:0] sdiv;
        logic [CB-1:0] sq;
    } stage_t;

    // floor(x / FULL) for x <= FULL*FULL: x = q1*FULL + (q1 + lo)
    function automatic logic [CB-1:0] div_full(input logic [PW-1:0] x);
        logic [CB:0] q;
        logic [CB:0] rm;
        q  = {1'b0, x[PW-1:CB]};
        rm = {1'b0, x[PW-1:CB]} + {1'b0, x[CB-1:0]};
        if (rm >= {1'b0, FULL})
        begin
            rm = rm - {1'b0, FULL};
            q  = q + 1'b1;
        end
        if (rm >= {1'b0, FULL})
        begin
            q = q + 1'b1;
        end
        return q[CB-1:0];
    endfunction

endpackage

// ===== design/hsvc_if.sv =====
// Pixel channel interfaces, input and result side.
interface hsvc_in_if;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [hsvc_pkg::CB-1:0]  comp_a;
    logic [hsvc_pkg::CB-1:0]  comp_b;
    logic [hsvc_pkg::CB-1:0]  comp_c;
    logic                     last_in;

    modport source (output valid, cmd, comp_a, comp_b, comp_c, last_in, input ready);
    modport sink   (input valid, cmd, comp_a, comp_b, comp_c, last_in, output ready);
endinterface

interface hsvc_out_if;
    logic                     valid;
    logic                     ready;
    logic [hsvc_pkg::CB-1:0]  out_a;
    logic [hsvc_pkg::CB-1:0]  out_b;
    logic [hsvc_pkg::CB-1:0]  out_c;
    logic                     last_out;

    modport source (output valid, out_a, out_b, out_c, last_out, input ready);
    modport sink   (input valid, out_a, out_b, out_c, last_out, output ready);
endinterface

// ===== design/hsv_rgb_pixel_converter.sv =====
// Top level: pipelined HSV <-> RGB pixel converter.
//
// Channels: pix_in carries one pixel item (cmd, comp_a..c, last_in); cmd 0
// converts HSV to RGB, cmd 1 converts RGB to HSV. pix_out carries one result
// item per input item, in order, with last_out copied from last_in.
// Both use valid/ready; an item moves on a rising edge with both high.
// The pipeline depth is set by the hue and saturation quotients, which resolve
// one bit per pipeline stage in a restoring divider. Throughput is one item
// per cycle while the receiver does not stall.
// Every stage has its own valid bit and moves whenever the stage after it
// is empty or moving, so bubbles close up while the receiver stalls, and
// input is taken until every stage holds an item.
// Reset empties the pipeline, so pix_in.ready is high during reset and after it.
// A stalled result holds steady on pix_out until taken.
module hsv_rgb_pixel_converter
(
    input  logic              clk,
    input  logic              rst_n,
    hsvc_in_if.sink           pix_in,
    hsvc_out_if.source        pix_out
);

    hsvc_pkg::stage_t         st_reg   [hsvc_pkg::NS];
    hsvc_pkg::stage_t         st_next  [hsvc_pkg::NS];
    hsvc_pkg::stage_t         entry_next;
    logic [hsvc_pkg::NS-1:0]  vld_reg;
    logic [hsvc_pkg::NS-1:0]  en;

    // Stage enables: a stage moves if empty or if its successor moves
    always_comb
    begin
        en[hsvc_pkg::NS-1] = !vld_reg[hsvc_pkg::NS-1] || pix_out.ready;
        for (int k = hsvc_pkg::NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign pix_in.ready = en[0];

    // Entry stage: sextant split or max/min/delta and hue numerator
    always_comb
    begin
        logic [hsvc_pkg::DW-1:0] h6;
        logic [hsvc_pkg::CB:0]   rm;
        logic [2:0]              sx;
        logic [hsvc_pkg::CB-1:0] mx;
        logic [hsvc_pkg::CB-1:0] mn;
        logic [hsvc_pkg::CB-1:0] d;
        logic [hsvc_pkg::DW-1:0] six;
        logic [hsvc_pkg::DW-1:0] num;
        hsvc_pkg::stage_t        s0;

        s0      = '0;
        s0.cmd  = pix_in.cmd;
        s0.last = pix_in.last_in;

        // HSV side
        h6 = hsvc_pkg::DW'({pix_in.comp_a, 2'b00}) + hsvc_pkg::DW'({pix_in.comp_a, 1'b0});
        sx = h6[hsvc_pkg::CB+2:hsvc_pkg::CB];
        rm = (hsvc_pkg::CB+1)'(sx) + (hsvc_pkg::CB+1)'(h6[hsvc_pkg::CB-1:0]);
        if (rm >= {1'b0, hsvc_pkg::FULL})
        begin
            rm = rm - {1'b0, hsvc_pkg::FULL};
            sx = sx + 3'd1;
        end
        if (rm >= {1'b0, hsvc_pkg::FULL})
        begin
            rm = rm - {1'b0, hsvc_pkg::FULL};
            sx = sx + 3'd1;
        end
        if (sx >= hsvc_pkg::SEXT_WRAP)
        begin
            sx = sx - hsvc_pkg::SEXT_WRAP;
        end

        // RGB side
        mx = pix_in.comp_a;
        if (pix_in.comp_b > mx) mx = pix_in.comp_b;
        if (pix_in.comp_c > mx) mx = pix_in.comp_c;
        mn = pix_in.comp_a;
        if (pix_in.comp_b < mn) mn = pix_in.comp_b;
        if (pix_in.comp_c < mn) mn = pix_in.comp_c;
        d   = mx - mn;
        six = hsvc_pkg::DW'({d, 2'b00}) + hsvc_pkg::DW'({d, 1'b0});
        if (pix_in.comp_a == mx)
        begin
            num = six + hsvc_pkg::DW'(pix_in.comp_b) - hsvc_pkg::DW'(pix_in.comp_c);
        end
        else if (pix_in.comp_b == mx)
        begin
            num = six + hsvc_pkg::DW'({d, 1'b0}) + hsvc_pkg::DW'(pix_in.comp_c)
                  - hsvc_pkg::DW'(pix_in.comp_a);
        end
        else
        begin
            num = six + hsvc_pkg::DW'({d, 2'b00}) + hsvc_pkg::DW'(pix_in.comp_a)
                  - hsvc_pkg::DW'(pix_in.comp_b);
        end
        if (num >= six)
        begin
            num = num - six;
        end

        if (pix_in.cmd == hsvc_pkg::CMD_HSV2RGB)
        begin
            s0.flat = (pix_in.comp_b == '0);
            s0.sext = sx;
            s0.s    = pix_in.comp_b;
            s0.v    = pix_in.comp_c;
            s0.fr   = rm[hsvc_pkg::CB-1:0];
        end
        else
        begin
            s0.flat = (mx == mn);
            s0.v    = mx;
            s0.hrem = hsvc_pkg::HW'(num);
            s0.hdiv = six;
            s0.srem = hsvc_pkg::PW'(d);
            s0.sdiv = mx;
        end
        entry_next = s0;
    end

    // Later stages: HSV products and FULL divisions, quotient bits for RGB
    always_comb
    begin
        hsvc_pkg::stage_t sk;
        st_next[0] = entry_next;
        for (int k = 1; k < hsvc_pkg::NS; k++)
        begin
            sk = st_reg[k-1];
            if (k == 1)
            begin
                sk.x0   = hsvc_pkg::PW'(sk.s) * hsvc_pkg::PW'(sk.fr);
                sk.x1   = hsvc_pkg::PW'(sk.s) * hsvc_pkg::PW'(hsvc_pkg::FULL - sk.fr);
                sk.x2   = hsvc_pkg::PW'(sk.v) * hsvc_pkg::PW'(hsvc_pkg::FULL - sk.s);
                sk.hrem = (sk.hrem << hsvc_pkg::CB) - sk.hrem;
                sk.srem = (sk.srem << hsvc_pkg::CB) - sk.srem;
            end
            else
            begin
                // one restoring step per stage, MSB first
                if (sk.hrem >= (hsvc_pkg::HW'(sk.hdiv) << (hsvc_pkg::NS - 1 - k)))
                begin
                    sk.hrem = sk.hrem - (hsvc_pkg::HW'(sk.hdiv) << (hsvc_pkg::NS - 1 - k));
                    sk.hq[hsvc_pkg::NS-1-k] = 1'b1;
                end
                if (sk.srem >= (hsvc_pkg::PW'(sk.sdiv) << (hsvc_pkg::NS - 1 - k)))
                begin
                    sk.srem = sk.srem - (hsvc_pkg::PW'(sk.sdiv) << (hsvc_pkg::NS - 1 - k));
                    sk.sq[hsvc_pkg::NS-1-k] = 1'b1;
                end
                if (k == 2)
                begin
                    sk.r0 = hsvc_pkg::div_full(sk.x0);   // s*f
                    sk.r1 = hsvc_pkg::div_full(sk.x1);   // s*(1-f)
                    sk.r2 = hsvc_pkg::div_full(sk.x2);   // p
                end
                else if (k == 3)
                begin
                    sk.x0 = hsvc_pkg::PW'(sk.v) * hsvc_pkg::PW'(hsvc_pkg::FULL - sk.r0);
                    sk.x1 = hsvc_pkg::PW'(sk.v) * hsvc_pkg::PW'(hsvc_pkg::FULL - sk.r1);
                end
                else if (k == 4)
                begin
                    sk.r0 = hsvc_pkg::div_full(sk.x0);   // q
                    sk.r1 = hsvc_pkg::div_full(sk.x1);   // t
                end
            end
            st_next[k] = sk;
        end
    end

    // Stage registers and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= pix_in.valid;
            end
            for (int k = 1; k < hsvc_pkg::NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < hsvc_pkg::NS; k++)
        begin
            if (en[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // Result selection from the last stage
    hsvc_pkg::stage_t fin;
    assign fin = st_reg[hsvc_pkg::NS-1];

    always_comb
    begin
        pix_out.out_a = fin.v;
        pix_out.out_b = fin.v;
        pix_out.out_c = fin.v;
        if (fin.cmd == hsvc_pkg::CMD_RGB2HSV)
        begin
            pix_out.out_a = fin.flat ? '0 : fin.hq;
            pix_out.out_b = fin.flat ? '0 : fin.sq;
        end
        else if (!fin.flat)
        begin
            // r0 = q, r1 = t, r2 = p
            case (fin.sext)
                hsvc_pkg::SEXT_0: begin pix_out.out_b = fin.r1; pix_out.out_c = fin.r2; end
                hsvc_pkg::SEXT_1: begin pix_out.out_a = fin.r0; pix_out.out_c = fin.r2; end
                hsvc_pkg::SEXT_2: begin pix_out.out_a = fin.r2; pix_out.out_c = fin.r1; end
                hsvc_pkg::SEXT_3: begin pix_out.out_a = fin.r2; pix_out.out_b = fin.r0; end
                hsvc_pkg::SEXT_4: begin pix_out.out_a = fin.r1; pix_out.out_b = fin.r2; end
                default:          begin pix_out.out_b = fin.r2; pix_out.out_c = fin.r0; end
            endcase
        end
    end

    assign pix_out.valid    = vld_reg[hsvc_pkg::NS-1];
    assign pix_out.last_out = fin.last;

`ifndef ASSERT_OFF
    // An empty output stage means every stage can move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_out.valid |-> pix_in.ready)
        else $error("input blocked while output stage empty");

    // An accepted item lands in the entry stage
    a_entry_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        pix_in.valid && pix_in.ready |=> vld_reg[0])
        else $error("accepted item lost at entry stage");

    // HSV to RGB: the value always appears in one of the channels
    a_value_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && fin.cmd == hsvc_pkg::CMD_HSV2RGB |->
        (pix_out.out_a == fin.v || pix_out.out_b == fin.v || pix_out.out_c == fin.v))
        else $error("value lost in sextant selection");
`endif

endmodule

// ===== sim/hsvc_tb_if.sv =====
// Testbench item types: one pixel as sent and one converted pixel as expected.
package hsvc_tb_types;
    import hsvc_pkg::*;

    // One pixel item as the sender presents it
    typedef struct packed {
        logic          cmd;
        logic [CB-1:0] a;
        logic [CB-1:0] b;
        logic [CB-1:0] c;
        logic          last;
    } pixel_t;

    // One converted pixel as the receiver should see it
    typedef struct packed {
        logic [CB-1:0] a;
        logic [CB-1:0] b;
        logic [CB-1:0] c;
        logic          last;
    } conv_t;
endpackage

// ===== sim/testbench.sv =====
// Self-checking testbench for the HSV/RGB pixel converter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hsvc_pkg::*;
    import hsvc_tb_types::*;

    localparam longint FS = (64'd1 << CB) - 1;

    logic clk;
    logic rst_n;
    hsvc_in_if  pix_in();
    hsvc_out_if pix_out();

    hsv_rgb_pixel_converter dut (.clk(clk), .rst_n(rst_n), .pix_in(pix_in), .pix_out(pix_out));

    pixel_t pending_pixels[$];
    conv_t  expected_pixels[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    int     errors;
    int     n_sent;
    int     n_checked;
    int     n_hsv;
    int     n_rgb;

    // Expected conversion of one pixel, done in wide integers
    function automatic conv_t convert_pixel(pixel_t px);
        conv_t  r;
        longint h, s, v, x, y, z, h6, sx, fr, p, q, t, sf, sg, mx, mn, d, num, six;
        r.last = px.last;
        if (px.cmd == CMD_HSV2RGB)
        begin
            h = px.a; s = px.b; v = px.c;
            if (s == 0)
            begin
                x = v; y = v; z = v;
            end
            else
            begin
                h6 = h * 6;
                sx = h6 / FS;
                fr = h6 - sx * FS;
                if (sx >= 6) sx -= 6;
                sf = (s * fr) / FS;
                sg = (s * (FS - fr)) / FS;
                p = (v * (FS - s)) / FS;
                q = (v * (FS - sf)) / FS;
                t = (v * (FS - sg)) / FS;
                case (sx)
                    0: begin x = v; y = t; z = p; end
                    1: begin x = q; y = v; z = p; end
                    2: begin x = p; y = v; z = t; end
                    3: begin x = p; y = q; z = v; end
                    4: begin x = t; y = p; z = v; end
                    default: begin x = v; y = p; z = q; end
                endcase
            end
        end
        else
        begin
            x = px.a; y = px.b; z = px.c;
            mx = x; if (y > mx) mx = y; if (z > mx) mx = z;
            mn = x; if (y < mn) mn = y; if (z < mn) mn = z;
            if (mx == mn)
            begin
                x = 0; y = 0; z = mx;
            end
            else
            begin
                d = mx - mn;
                six = 6 * d;
                // hue numerator biased by six deltas to stay non-negative
                if (x == mx)      num = six + y - z;
                else if (y == mx) num = six + 2 * d + z - x;
                else              num = six + 4 * d + x - y;
                if (num >= six) num -= six;
                x = (num * FS) / six;
                y = (d * FS) / mx;
                z = mx;
            end
        end
        r.a = x[CB-1:0];
        r.b = y[CB-1:0];
        r.c = z[CB-1:0];
        return r;
    endfunction

    function automatic logic [CB-1:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return FULL;
            2: return CB'($urandom_range(0, 15));
            3: return FULL - CB'($urandom_range(0, 15));
            default: return CB'($urandom);
        endcase
    endfunction

    // Queue one pixel and count it by direction
    task automatic add_pixel(logic cmd, logic [CB-1:0] a, logic [CB-1:0] b,
                             logic [CB-1:0] c, logic last);
        pixel_t px;
        px = '{cmd: cmd, a: a, b: b, c: c, last: last};
        pending_pixels.push_back(px);
        if (cmd == CMD_HSV2RGB) n_hsv++;
        else n_rgb++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sender: presents the head of the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_in.valid   <= 1'b0;
            pix_in.cmd     <= 1'b0;
            pix_in.comp_a  <= '0;
            pix_in.comp_b  <= '0;
            pix_in.comp_c  <= '0;
            pix_in.last_in <= 1'b0;
        end
        else
        begin
            if (pix_in.valid && pix_in.ready)
            begin
                expected_pixels.push_back(convert_pixel(pending_pixels.pop_front()));
                n_sent++;
            end
            if ((!pix_in.valid || pix_in.ready) && pending_pixels.size() > 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                pix_in.valid   <= 1'b1;
                pix_in.cmd     <= pending_pixels[0].cmd;
                pix_in.comp_a  <= pending_pixels[0].a;
                pix_in.comp_b  <= pending_pixels[0].b;
                pix_in.comp_c  <= pending_pixels[0].c;
                pix_in.last_in <= pending_pixels[0].last;
            end
            else if (!pix_in.valid || pix_in.ready)
            begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls and checks each result item
    always @(posedge clk or negedge rst_n)
    begin
        conv_t want;
        if (!rst_n)
        begin
            pix_out.ready <= 1'b0;
        end
        else
        begin
            if (pix_out.valid && pix_out.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result item with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    n_checked++;
                    if (pix_out.out_a !== want.a)
                    begin
                        $error("out_a: expected %0d, got %0d", want.a, pix_out.out_a);
                        errors++;
                    end
                    if (pix_out.out_b !== want.b)
                    begin
                        $error("out_b: expected %0d, got %0d", want.b, pix_out.out_b);
                        errors++;
                    end
                    if (pix_out.out_c !== want.c)
                    begin
                        $error("out_c: expected %0d, got %0d", want.c, pix_out.out_c);
                        errors++;
                    end
                    if (pix_out.last_out !== want.last)
                    begin
                        $error("last_out: expected %0d, got %0d", want.last, pix_out.last_out);
                        errors++;
                    end
                end
            end
            pix_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [CB-1:0] g;
        int k;
        errors = 0; n_sent = 0; n_checked = 0; n_hsv = 0; n_rgb = 0;
        send_idle_pct = 33;
        recv_idle_pct = 75;
        rst_n = 1'b0;
        pix_in.valid = 1'b0;
        pix_in.cmd = 1'b0;
        pix_in.comp_a = '0;
        pix_in.comp_b = '0;
        pix_in.comp_c = '0;
        pix_in.last_in = 1'b0;
        pix_out.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, grey, full-scale hue, every sextant, equal channels
        add_pixel(CMD_HSV2RGB, '0, '0, '0, 1'b0);
        add_pixel(CMD_HSV2RGB, FULL, FULL, FULL, 1'b1);
        add_pixel(CMD_HSV2RGB, 16'h1234, '0, 16'h8000, 1'b0);
        add_pixel(CMD_HSV2RGB, '0, FULL, FULL, 1'b0);
        add_pixel(CMD_HSV2RGB, FULL, 16'h8000, 16'hC000, 1'b0);
        for (k = 0; k < 6; k++)
            add_pixel(CMD_HSV2RGB, CB'((FS * k) / 6 + 1000), 16'hA000, FULL, k[0]);
        add_pixel(CMD_RGB2HSV, '0, '0, '0, 1'b0);
        add_pixel(CMD_RGB2HSV, FULL, FULL, FULL, 1'b1);
        add_pixel(CMD_RGB2HSV, 16'h4242, 16'h4242, 16'h4242, 1'b0);
        add_pixel(CMD_RGB2HSV, FULL, '0, '0, 1'b0);
        add_pixel(CMD_RGB2HSV, '0, FULL, '0, 1'b0);
        add_pixel(CMD_RGB2HSV, '0, '0, FULL, 1'b0);
        add_pixel(CMD_RGB2HSV, FULL, '0, 16'h0001, 1'b0);
        add_pixel(CMD_RGB2HSV, FULL, FULL, '0, 1'b0);
        add_pixel(CMD_RGB2HSV, '0, FULL, FULL, 1'b1);
        add_pixel(CMD_RGB2HSV, 16'h0001, '0, '0, 1'b0);

        // Random, in three idling phases
        for (k = 0; k < 900; k++)
        begin
            if (k == 300)
            begin
                wait (pending_pixels.size() == 0);
                send_idle_pct = 75;
                recv_idle_pct = 33;
            end
            if (k == 600)
            begin
                wait (pending_pixels.size() == 0);
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                g = rand_comp();
                add_pixel(CMD_RGB2HSV, g, g, g, 1'($urandom));
            end
            else
                add_pixel(1'($urandom), rand_comp(), rand_comp(), rand_comp(), 1'($urandom));
        end

        wait (pending_pixels.size() == 0 && !pix_in.valid);
        wait (expected_pixels.size() == 0);
        repeat (2 * NS + 10) @(posedge clk);
        $display("Converted %0d pixels: %0d HSV to RGB, %0d RGB to HSV, %0d checked.",
                 n_sent, n_hsv, n_rgb, n_checked);
        $display("Idling phases: sender-heavy, receiver-heavy, and none.");
        if (errors == 0)
            $display("** hsv_rgb_pixel_converter: PASSED **");
        else
            $display("** hsv_rgb_pixel_converter: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("Timeout waiting for the pipeline to drain.");
        $display("** hsv_rgb_pixel_converter: FAILED **");
        $finish;
    end
endmodule

// ===== files.f =====
design/hsvc_pkg.sv
design/hsvc_if.sv
design/hsv_rgb_pixel_converter.sv
sim/hsvc_tb_if.sv
sim/testbench.sv
